FILE: hdl/pave_pkg.sv
package pave_pkg;

	// operation codes
	localparam logic [1:0] OP_TICK     = 2'd0;
	localparam logic [1:0] OP_NOTE_ON  = 2'd1;
	localparam logic [1:0] OP_NOTE_OFF = 2'd2;

	// envelope stage codes
	localparam logic [2:0] STG_IDLE    = 3'd0;
	localparam logic [2:0] STG_ATTACK  = 3'd1;
	localparam logic [2:0] STG_DECAY   = 3'd2;
	localparam logic [2:0] STG_SUSTAIN = 3'd3;
	localparam logic [2:0] STG_RELEASE = 3'd4;

	// waveform codes
	localparam logic [1:0] WAVE_SIN = 2'd0;
	localparam logic [1:0] WAVE_SQR = 2'd1;
	localparam logic [1:0] WAVE_SAW = 2'd2;
	localparam logic [1:0] WAVE_TRI = 2'd3;

	// register indexes
	localparam logic [2:0] CFG_ATTACK    = 3'd0;
	localparam logic [2:0] CFG_DECAY     = 3'd1;
	localparam logic [2:0] CFG_SUSTAIN   = 3'd2;
	localparam logic [2:0] CFG_RELEASE   = 3'd3;
	localparam logic [2:0] CFG_WAVE      = 3'd4;
	localparam logic [2:0] CFG_TOLERANCE = 3'd5;

	localparam logic [24:0] ENV_ONE     = 25'd16777216;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

	localparam logic [24:0] ATTACK_RST    = 25'd7609;
	localparam logic [24:0] DECAY_RST     = 25'd3804;
	localparam logic [24:0] SUSTAIN_RST   = 25'd13421773;
	localparam logic [24:0] RELEASE_RST   = 25'd609;
	localparam logic [1:0]  WAVE_RST      = WAVE_SAW;
	localparam logic [23:0] TOLERANCE_RST = 24'd38;

	typedef struct packed {
		logic [1:0]  op;
		logic [23:0] phase_step;
	} req_t;

	typedef struct packed {
		logic signed [15:0] sample;
		logic [2:0]         voice_index;
		logic               accepted;
		logic [3:0]         active_voices;
	} rsp_t;

	// round(32767*sin x), x in q30 radians over a quarter wave
	function automatic logic [15:0] quarter_sine(input logic [63:0] x);
		logic [63:0] x2;
		logic [63:0] t;
		logic signed [63:0] s;
		logic [63:0] v;
		x2 = (x * x) >> 30;
		t  = x;
		s  = $signed(x);
		t  = ((t * x2) >> 30) / 64'd6;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd20;
		s  = s + $signed(t);
		t  = ((t * x2) >> 30) / 64'd42;
		s  = s - $signed(t);
		t  = ((t * x2) >> 30) / 64'd72;
		s  = s + $signed(t);
		if (s < 0) begin
			s = 64'sd0;
		end
		v = (64'($unsigned(s)) * 64'd32767 + (64'd1 << 29)) >> 30;
		if (v > 64'd32767) begin
			v = 64'd32767;
		end
		return v[15:0];
	endfunction

endpackage

FILE: hdl/pave_ram.sv
module pave_ram #(
	parameter int WIDTH = 76,
	parameter int DEPTH = 8
) (
	input  logic                                  clk,
	input  logic                                  we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                      wdata,
	input  logic                                  re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: hdl/pave_div.sv
// soft-clip divider: quo = mag*2^24 / (2^24 + mag), one quotient bit a cycle
module pave_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [24:0] mag,
	output logic        done,
	output logic [23:0] quo
);

	logic [25:0] rem_q;
	logic [25:0] den_q;
	logic [23:0] quo_q;
	logic [4:0]  cnt_q;
	logic        busy_q;
	logic        done_q;
	logic [26:0] shifted;
	logic        fits;

	assign shifted = {rem_q, 1'b0};
	assign fits    = shifted >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 5'd1;
				if (cnt_q == 5'd23) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, mag};
			den_q <= 26'd16777216 + {1'b0, mag};
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? 26'(shifted - {1'b0, den_q}) : shifted[25:0];
			quo_q <= {quo_q[22:0], fits};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: hdl/polyphonic_adsr_voice_engine.sv
// note-on and unknown ops go straight to the result register; note-off and sample tick walk
// over every voice slot, and a sample tick passes each active voice in turn through the
// soft-clip divider
// throughput: one transaction at a time; the next is taken once the result is registered
// reset: arst_n clears the voice-active flags, the sequencer and the registers to defaults;
// voice memory is not cleared, a voice entry is always written by note-on before use
module polyphonic_adsr_voice_engine #(
	parameter int VOICE_COUNT      = 8,
	parameter int PHASE_BITS       = 24,
	parameter int SINE_TABLE_DEPTH = 256
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             req_valid,
	output logic             req_stall,
	input  pave_pkg::req_t   req,
	output logic             rsp_valid,
	input  logic             rsp_stall,
	output pave_pkg::rsp_t   rsp,
	input  logic             cfg_we,
	input  logic [2:0]       cfg_index,
	input  logic [24:0]      cfg_data
);

	localparam int AW  = VOICE_COUNT > 1 ? $clog2(VOICE_COUNT) : 1;
	localparam int VCW = $clog2(VOICE_COUNT + 1);
	localparam int EW  = PHASE_BITS + 52;
	localparam int SW  = PHASE_BITS > 24 ? PHASE_BITS : 24;
	localparam int SIW = $clog2(SINE_TABLE_DEPTH);

	// sequencer, one-hot
	typedef enum logic [8:0] {
		FSM_IDLE     = 9'b000000001,
		FSM_TICK_RD  = 9'b000000010,
		FSM_TICK_EXE = 9'b000000100,
		FSM_TICK_MUL = 9'b000001000,
		FSM_TICK_ADD = 9'b000010000,
		FSM_TICK_DIV = 9'b000100000,
		FSM_OFF_RD   = 9'b001000000,
		FSM_OFF_CHK  = 9'b010000000,
		FSM_DONE     = 9'b100000000
	} fsm_t;

	fsm_t state_q;

	// configuration registers
	logic [24:0] attack_q, decay_q, sustain_q, release_q;
	logic [1:0]  wave_q;
	logic [23:0] tol_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attack_q  <= pave_pkg::ATTACK_RST;
			decay_q   <= pave_pkg::DECAY_RST;
			sustain_q <= pave_pkg::SUSTAIN_RST;
			release_q <= pave_pkg::RELEASE_RST;
			wave_q    <= pave_pkg::WAVE_RST;
			tol_q     <= pave_pkg::TOLERANCE_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				pave_pkg::CFG_ATTACK:    attack_q  <= cfg_data;
				pave_pkg::CFG_DECAY:     decay_q   <= cfg_data;
				pave_pkg::CFG_SUSTAIN:   sustain_q <= cfg_data;
				pave_pkg::CFG_RELEASE:   release_q <= cfg_data;
				pave_pkg::CFG_WAVE:      wave_q    <= cfg_data[1:0];
				pave_pkg::CFG_TOLERANCE: tol_q     <= cfg_data[23:0];
				default: ;
			endcase
		end
	end

	// sine table, worked out at elaboration
	logic signed [16:0] sine_rom [SINE_TABLE_DEPTH];

	for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
		localparam int          QK = (4 * k) / SINE_TABLE_DEPTH;
		localparam int          RK = 4 * k - QK * SINE_TABLE_DEPTH;
		localparam logic [63:0] AK = 64'((QK % 2 == 1) ? SINE_TABLE_DEPTH - RK : RK);
		localparam logic [63:0] XK = (pave_pkg::HALF_PI_Q30 * AK) / SINE_TABLE_DEPTH;
		localparam logic [15:0] VK = pave_pkg::quarter_sine(XK);
		assign sine_rom[k] = (QK >= 2) ? -$signed({1'b0, VK}) : $signed({1'b0, VK});
	end

	logic [VOICE_COUNT-1:0] active_q;
	logic [VCW-1:0]         vcnt_q;
	logic [AW-1:0]          vidx;
	logic                   vcnt_end;

	assign vidx     = vcnt_q[AW-1:0];
	assign vcnt_end = vcnt_q == VCW'(VOICE_COUNT);

	// voice memory: {stage, level, step, phase}
	logic          ram_we, ram_re;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata, ram_rdata;

	pave_ram #(.WIDTH(EW), .DEPTH(VOICE_COUNT)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (vidx),
		.rdata (ram_rdata)
	);

	// fields of the entry just read
	logic [PHASE_BITS-1:0] rd_phase;
	logic [23:0]           rd_step;
	logic [24:0]           rd_level;
	logic [2:0]            rd_stage;

	assign rd_phase = ram_rdata[PHASE_BITS-1:0];
	assign rd_step  = ram_rdata[PHASE_BITS +: 24];
	assign rd_level = ram_rdata[PHASE_BITS+24 +: 25];
	assign rd_stage = ram_rdata[PHASE_BITS+49 +: 3];

	// first free voice for note-on
	logic          free_found;
	logic [AW-1:0] free_idx;

	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = VOICE_COUNT - 1; i >= 0; i--) begin
			if (!active_q[i]) begin
				free_found = 1'b1;
				free_idx   = AW'(i);
			end
		end
	end

	// oscillator
	logic [SW-1:0]              phase_sum;
	logic [PHASE_BITS-1:0]      new_phase;
	logic [PHASE_BITS+SIW-1:0]  sine_prod;
	logic [SIW-1:0]             sine_idx;
	logic [15:0]                p16;
	logic signed [16:0]         saw;
	logic signed [17:0]         tri_d;
	logic signed [17:0]         tri_v;
	logic signed [16:0]         wave;

	assign phase_sum = SW'(rd_phase) + SW'(rd_step);
	assign new_phase = phase_sum[PHASE_BITS-1:0];
	assign sine_prod = (PHASE_BITS+SIW)'(new_phase) * (PHASE_BITS+SIW)'(SINE_TABLE_DEPTH);
	assign sine_idx  = sine_prod[PHASE_BITS +: SIW];
	assign p16       = new_phase[PHASE_BITS-1 -: 16];
	assign saw       = $signed({1'b0, p16}) - 17'sd32768;
	assign tri_d     = saw < 0 ? -18'(saw) : 18'(saw);
	assign tri_v     = 18'(tri_d <<< 1) - 18'sd32768;

	always_comb begin
		case (wave_q)
			pave_pkg::WAVE_SIN: wave = sine_rom[sine_idx];
			pave_pkg::WAVE_SQR: wave = new_phase[PHASE_BITS-1] ? -17'sd32768 : 17'sd32768;
			pave_pkg::WAVE_SAW: wave = saw;
			default:            wave = tri_v[16:0];
		endcase
	end

	// envelope
	logic [24:0]        sus_eff;
	logic [25:0]        att_sum;
	logic signed [26:0] dec_diff, rel_diff;
	logic [24:0]        new_level;
	logic [2:0]         new_stage;

	assign sus_eff  = sustain_q > pave_pkg::ENV_ONE ? pave_pkg::ENV_ONE : sustain_q;
	assign att_sum  = {1'b0, rd_level} + {1'b0, attack_q};
	assign dec_diff = $signed({2'b0, rd_level}) - $signed({2'b0, decay_q});
	assign rel_diff = $signed({2'b0, rd_level}) - $signed({2'b0, release_q});

	always_comb begin
		new_level = rd_level;
		new_stage = rd_stage;
		case (rd_stage)
			pave_pkg::STG_ATTACK: begin
				if (att_sum >= {1'b0, pave_pkg::ENV_ONE}) begin
					new_level = pave_pkg::ENV_ONE;
					new_stage = pave_pkg::STG_DECAY;
				end else begin
					new_level = att_sum[24:0];
				end
			end
			pave_pkg::STG_DECAY: begin
				if (dec_diff <= $signed({2'b0, sus_eff})) begin
					new_level = sus_eff;
					new_stage = pave_pkg::STG_SUSTAIN;
				end else begin
					new_level = dec_diff[24:0];
				end
			end
			pave_pkg::STG_SUSTAIN: ;
			pave_pkg::STG_RELEASE: begin
				if (rel_diff <= 27'sd0) begin
					new_level = '0;
					new_stage = pave_pkg::STG_IDLE;
				end else begin
					new_level = rel_diff[24:0];
				end
			end
			default: begin
				// idle and codes that mean nothing fall to idle
				new_level = '0;
				new_stage = pave_pkg::STG_IDLE;
			end
		endcase
	end

	// transaction held for the walk over the voices
	pave_pkg::req_t req_q;

	// note-off match
	logic [23:0] step_diff;
	logic        off_match;

	assign step_diff = rd_step >= req_q.phase_step ? rd_step - req_q.phase_step
	                                               : req_q.phase_step - rd_step;
	assign off_match = step_diff < tol_q;

	// mix datapath
	logic signed [16:0] wave_s1;
	logic [24:0]        level_s1;
	logic signed [42:0] prod_s2;
	logic signed [42:0] prod_bias;
	logic signed [25:0] term;
	logic signed [25:0] mix_q;
	logic signed [25:0] mix_next;
	logic [24:0]        mix_mag;
	logic               sign_q;
	logic               div_start, div_done;
	logic [23:0]        div_quo;
	logic [2:0]         vsel_q;
	logic               acc_q;
	logic signed [25:0] smp_bias;
	logic signed [25:0] smp_full;

	// truncate toward zero on both scalings
	assign prod_bias = prod_s2 + (prod_s2 < 0 ? 43'sd32767 : 43'sd0);
	assign term      = 26'(prod_bias >>> 15);
	assign mix_next  = mix_q + term;
	assign mix_mag   = mix_next < 0 ? 25'(-mix_next) : mix_next[24:0];
	assign div_start = state_q == FSM_TICK_ADD;
	assign smp_bias  = mix_q + (mix_q < 0 ? 26'sd511 : 26'sd0);
	assign smp_full  = smp_bias >>> 9;

	pave_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.mag    (mix_mag),
		.done   (div_done),
		.quo    (div_quo)
	);

	always_ff @(posedge clk) begin
		if (state_q == FSM_TICK_EXE) begin
			wave_s1  <= wave;
			level_s1 <= new_level;
		end
		if (state_q == FSM_TICK_MUL) begin
			prod_s2 <= 43'(wave_s1) * $signed({18'b0, level_s1});
		end
	end

	// memory control
	always_comb begin
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_waddr = vidx;
		ram_wdata = ram_rdata;
		case (state_q)
			FSM_IDLE: begin
				// note-on claims the first free voice straight away
				ram_we    = req_valid && req.op == pave_pkg::OP_NOTE_ON && free_found;
				ram_waddr = free_idx;
				ram_wdata = {pave_pkg::STG_ATTACK, 25'd0, req.phase_step,
				             {PHASE_BITS{1'b0}}};
			end
			FSM_TICK_RD, FSM_OFF_RD: ram_re = !vcnt_end && active_q[vidx];
			FSM_TICK_EXE: begin
				ram_we    = 1'b1;
				ram_wdata = {new_stage, new_level, rd_step, new_phase};
			end
			FSM_OFF_CHK: begin
				ram_we    = off_match && rd_stage != pave_pkg::STG_IDLE;
				ram_wdata = {pave_pkg::STG_RELEASE, rd_level, rd_step, rd_phase};
			end
			default: ;
		endcase
	end

	logic rsp_load;

	assign rsp_load  = state_q == FSM_DONE && (!rsp_valid || !rsp_stall);
	assign req_stall = state_q != FSM_IDLE;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= FSM_IDLE;
			active_q  <= '0;
			vcnt_q    <= '0;
			rsp_valid <= 1'b0;
			acc_q     <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid <= 1'b1;
			end else if (rsp_valid && !rsp_stall) begin
				rsp_valid <= 1'b0;
			end
			case (state_q)
				FSM_IDLE: begin
					vcnt_q <= '0;
					acc_q  <= req_valid && req.op == pave_pkg::OP_NOTE_ON && free_found;
					if (req_valid) begin
						case (req.op)
							pave_pkg::OP_TICK:     state_q <= FSM_TICK_RD;
							pave_pkg::OP_NOTE_OFF: state_q <= FSM_OFF_RD;
							pave_pkg::OP_NOTE_ON: begin
								state_q <= FSM_DONE;
								if (free_found) begin
									active_q[free_idx] <= 1'b1;
								end
							end
							default: state_q <= FSM_DONE;
						endcase
					end
				end
				FSM_TICK_RD: begin
					if (vcnt_end) begin
						state_q <= FSM_DONE;
					end else if (active_q[vidx]) begin
						state_q <= FSM_TICK_EXE;
					end else begin
						vcnt_q <= vcnt_q + VCW'(1);
					end
				end
				FSM_TICK_EXE: begin
					// a voice whose envelope ends is freed
					if (new_stage == pave_pkg::STG_IDLE) begin
						active_q[vidx] <= 1'b0;
					end
					state_q <= FSM_TICK_MUL;
				end
				FSM_TICK_MUL: state_q <= FSM_TICK_ADD;
				FSM_TICK_ADD: state_q <= FSM_TICK_DIV;
				FSM_TICK_DIV: begin
					if (div_done) begin
						vcnt_q  <= vcnt_q + VCW'(1);
						state_q <= FSM_TICK_RD;
					end
				end
				FSM_OFF_RD: begin
					if (vcnt_end) begin
						state_q <= FSM_DONE;
					end else if (active_q[vidx]) begin
						state_q <= FSM_OFF_CHK;
					end else begin
						vcnt_q <= vcnt_q + VCW'(1);
					end
				end
				FSM_OFF_CHK: begin
					if (off_match) begin
						acc_q <= 1'b1;
					end
					vcnt_q  <= vcnt_q + VCW'(1);
					state_q <= FSM_OFF_RD;
				end
				FSM_DONE: begin
					if (rsp_load) begin
						state_q <= FSM_IDLE;
					end
				end
				default: state_q <= FSM_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (state_q == FSM_IDLE) begin
			req_q  <= req;
			mix_q  <= '0;
			vsel_q <= free_found ? 3'(free_idx) : 3'd0;
		end
		if (state_q == FSM_TICK_ADD) begin
			sign_q <= mix_next < 0;
		end
		if (state_q == FSM_TICK_DIV && div_done) begin
			mix_q <= sign_q ? -$signed({2'b0, div_quo}) : $signed({2'b0, div_quo});
		end
		if (rsp_load) begin
			rsp.sample        <= smp_full[15:0];
			rsp.voice_index   <= (req_q.op == pave_pkg::OP_NOTE_ON) ? vsel_q : 3'd0;
			rsp.accepted      <= acc_q;
			rsp.active_voices <= 4'($countones(active_q));
		end
	end

endmodule
